[hw/rtl/lpf_pkg.sv]
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types, codes and helpers of the layer pixel palette formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package lpf_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned COMP_W     = 8;
  localparam int unsigned RGB_W      = 3 * COMP_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [PIX_W-1:0] HI_BLUE_MASK  = 16'h001f;
  localparam logic [PIX_W-1:0] HI_GREEN_MASK = 16'h7c00;
  localparam logic [PIX_W-1:0] HI_RED_MASK   = 16'h03e0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER0_MODE     = 3'd0,
    CFG_LAYER1_MODE     = 3'd1,
    CFG_SECOND_LAYER_ON = 3'd2,
    CFG_HZOOM_LAYER0    = 3'd3,
    CFG_HZOOM_LAYER1    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_16  = 2'd1,
    MODE_256 = 2'd2,
    MODE_HI  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PORT_SEL   = 2'd0,
    PORT_BLUE  = 2'd1,
    PORT_RED   = 2'd2,
    PORT_GREEN = 2'd3
  } port_e;

  typedef enum logic {
    REQ_PORT  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_e;

  typedef struct packed {
    logic              sel_we;
    logic              comp_we;
    port_e             port;
    logic [COMP_W-1:0] data;
  } pal_wr_t;

  typedef struct packed {
    mode_e            mode;
    logic             zoom;
    logic             op_a;
    logic             op_b;
    logic             rng_a;
    logic             rng_b;
    logic [RGB_W-1:0] hc_rgb;
  } meta_t;

  // xGGGGGRRRRRBBBBB to red, green, blue bytes
  function automatic logic [RGB_W-1:0] hicolour(input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
    b = c & HI_BLUE_MASK;
    g = c & HI_GREEN_MASK;
    r = c & HI_RED_MASK;
    return {r[9:5], 3'b000, g[14:10], 3'b000, b[4:0], 3'b000};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lpf_if.sv]
// ----------------------------------------------------------------------------
// lpf_if
// Valid/ready channels of the formatter: request beats in, pixel beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [1:0]                 port;
  logic [lpf_pkg::PIX_W-1:0]  pixel_data;
  logic                       layer;

  modport source (output valid, req_type, port, pixel_data, layer, input ready);
  modport sink   (input valid, req_type, port, pixel_data, layer, output ready);
endinterface

interface lpf_out_if;
  logic                       valid;
  logic                       ready;
  logic [lpf_pkg::RGB_W-1:0]  rgb;
  logic                       opaque;
  logic                       last;

  modport source (output valid, rgb, opaque, last, input ready);
  modport sink   (input valid, rgb, opaque, last, output ready);
endinterface

`default_nettype wire

[hw/rtl/lpf_palette.sv]
// ----------------------------------------------------------------------------
// lpf_palette
// Palette memory with byte-lane component writes, entry select register,
// a clearing pass after reset and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_palette #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned AW              = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lpf_pkg::pal_wr_t          wr_i,
  input  wire logic                      rd_en_i,
  input  wire logic [AW-1:0]             rd_addr_a_i,
  input  wire logic [AW-1:0]             rd_addr_b_i,
  output logic                           busy_o,
  output logic [lpf_pkg::RGB_W-1:0]      rd_data_a_o,
  output logic [lpf_pkg::RGB_W-1:0]      rd_data_b_o
);

  localparam logic [lpf_pkg::COMP_W:0] ENTRIES_W = (lpf_pkg::COMP_W + 1)'(PALETTE_ENTRIES);
  localparam logic [AW-1:0]            CLR_LAST  = AW'(PALETTE_ENTRIES - 1);

  logic [lpf_pkg::RGB_W-1:0]  mem_q [PALETTE_ENTRIES];
  logic [lpf_pkg::COMP_W-1:0] idx_q;
  logic                       clr_busy_q;
  logic [AW-1:0]              clr_addr_q;
  logic [lpf_pkg::RGB_W-1:0]  rdata_a_q, rdata_b_q;
  logic                       wr_ok;
  logic [AW-1:0]              waddr;

  assign wr_ok = wr_i.comp_we && ({1'b0, idx_q} < ENTRIES_W);
  assign waddr = idx_q[AW-1:0];

  // one entry cleared per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      if (wr_i.sel_we) begin
        idx_q <= wr_i.data;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == CLR_LAST) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_ok) begin
      unique case (wr_i.port)
        lpf_pkg::PORT_BLUE:  mem_q[waddr][7:0]   <= wr_i.data;
        lpf_pkg::PORT_GREEN: mem_q[waddr][15:8]  <= wr_i.data;
        lpf_pkg::PORT_RED:   mem_q[waddr][23:16] <= wr_i.data;
        default: ;
      endcase
    end
    if (rd_en_i) begin
      rdata_a_q <= mem_q[rd_addr_a_i];
      rdata_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign busy_o      = clr_busy_q;
  assign rd_data_a_o = rdata_a_q;
  assign rd_data_b_o = rdata_b_q;

endmodule

`default_nettype wire

[hw/rtl/lpf_emit.sv]
// ----------------------------------------------------------------------------
// lpf_emit
// Holds one pixel word after the palette read and expands it into one to
// four pixel beats through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_emit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire lpf_pkg::meta_t            meta_i,
  input  wire logic [lpf_pkg::RGB_W-1:0] rd_data_a_i,
  input  wire logic [lpf_pkg::RGB_W-1:0] rd_data_b_i,
  output logic                           ready_o,
  lpf_out_if.source                      pix_o
);

  lpf_pkg::meta_t            meta_q;
  logic                      s1_valid_q, s1_valid_d;
  logic [1:0]                cnt_q, cnt_d;
  logic                      out_valid_q;
  logic [lpf_pkg::RGB_W-1:0] rgb_q;
  logic                      opaque_q, last_q;

  logic                      is16;
  logic [1:0]                last_idx;
  logic                      last_beat;
  logic                      pix_sel;
  logic                      load_out;
  logic                      fin;
  logic [lpf_pkg::RGB_W-1:0] col;
  logic                      op;

  assign is16      = (meta_q.mode == lpf_pkg::MODE_16);
  assign last_idx  = {is16 & meta_q.zoom, is16 | meta_q.zoom};
  assign last_beat = (cnt_q == last_idx);
  assign pix_sel   = meta_q.zoom ? cnt_q[1] : cnt_q[0];
  assign load_out  = s1_valid_q && (!out_valid_q || pix_o.ready);
  assign fin       = load_out && last_beat;
  assign ready_o   = !s1_valid_q || fin;

  always_comb begin
    col = '0;
    op  = 1'b0;
    unique case (meta_q.mode)
      lpf_pkg::MODE_HI: begin
        col = meta_q.hc_rgb;
        op  = meta_q.op_a;
      end
      default: begin
        if (pix_sel) begin
          col = meta_q.rng_b ? rd_data_b_i : '0;
          op  = meta_q.op_b;
        end else begin
          col = meta_q.rng_a ? rd_data_a_i : '0;
          op  = meta_q.op_a;
        end
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    cnt_d      = cnt_q;
    if (load_out) begin
      cnt_d = cnt_q + 2'd1;
    end
    if (fin) begin
      s1_valid_d = 1'b0;
    end
    if (load_i) begin
      s1_valid_d = 1'b1;
      cnt_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      meta_q <= meta_i;
    end
    if (load_out) begin
      rgb_q    <= op ? col : '0;
      opaque_q <= op;
      last_q   <= last_beat;
    end
  end

  assign pix_o.valid  = out_valid_q;
  assign pix_o.rgb    = rgb_q;
  assign pix_o.opaque = opaque_q;
  assign pix_o.last   = last_q;

endmodule

`default_nettype wire

[hw/rtl/layer_pixel_palette_formatter_unit.sv]
// ----------------------------------------------------------------------------
// layer_pixel_palette_formatter_unit
// Graphics-layer pixel formatter with a palette of RGB colours.
// ----------------------------------------------------------------------------
// Request beats arrive on pix_i. A beat with req_type 0 is a palette port
// write: it sets the entry select or writes one colour component, and gives
// no pixel. A beat with req_type 1 is a video word for layer 0 or 1, which
// is formatted by that layer's mode: sixteen colours give two pixels (low
// nibble first), 256 colours and highcolour give one, and horizontal zoom
// doubles each pixel. Pixel beats leave on pix_o; last marks the final one
// of a word. Disabled layers and off modes give no beat.
// The palette is read at the edge a word is accepted, into the palette read
// registers; its first pixel beat then passes through the output register.
// A word gives its pixel beats (one to four) through the single output
// register, one per cycle while pix_o is not stalled. The next word is
// accepted in the cycle its predecessor's last beat is loaded.
// Reset clears the configuration and the entry select, then a clearing pass
// zeroes one palette entry per cycle, all PALETTE_ENTRIES of them (256 by
// default); pix_i is held off until the pass ends.
// When pix_o stalls, the held beat stays and pix_i is held off until the
// word being expanded can move on.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_pixel_palette_formatter_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  lpf_in_if.sink                                   pix_i,
  lpf_out_if.source                                pix_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [lpf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [lpf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [lpf_pkg::COMP_W:0] ENTRIES_W = (lpf_pkg::COMP_W + 1)'(PALETTE_ENTRIES);

  lpf_pkg::mode_e layer0_mode_q, layer1_mode_q;
  logic           second_on_q, hzoom0_q, hzoom1_q;

  lpf_pkg::mode_e             mode_sel;
  logic                       zoom_sel;
  logic                       layer_en;
  logic                       is_pixel;
  logic                       accept;
  logic                       load;
  logic                       emit_ready;
  logic                       pal_busy;
  logic                       in_ready;
  logic [lpf_pkg::COMP_W-1:0] idx_a, idx_b;
  logic                       rng_a, rng_b;
  logic [AW-1:0]              addr_a, addr_b;
  lpf_pkg::pal_wr_t           wr;
  lpf_pkg::meta_t             meta;
  logic [lpf_pkg::RGB_W-1:0]  rd_data_a, rd_data_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer0_mode_q <= lpf_pkg::MODE_OFF;
      layer1_mode_q <= lpf_pkg::MODE_OFF;
      second_on_q   <= 1'b0;
      hzoom0_q      <= 1'b0;
      hzoom1_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (lpf_pkg::cfg_idx_e'(cfg_idx_i))
        lpf_pkg::CFG_LAYER0_MODE:     layer0_mode_q <= lpf_pkg::mode_e'(cfg_data_i);
        lpf_pkg::CFG_LAYER1_MODE:     layer1_mode_q <= lpf_pkg::mode_e'(cfg_data_i);
        lpf_pkg::CFG_SECOND_LAYER_ON: second_on_q   <= cfg_data_i[0];
        lpf_pkg::CFG_HZOOM_LAYER0:    hzoom0_q      <= cfg_data_i[0];
        lpf_pkg::CFG_HZOOM_LAYER1:    hzoom1_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_sel = pix_i.layer ? layer1_mode_q : layer0_mode_q;
    zoom_sel = pix_i.layer ? hzoom1_q : hzoom0_q;
    layer_en = (mode_sel != lpf_pkg::MODE_OFF) && (!pix_i.layer || second_on_q);
    is_pixel = (lpf_pkg::req_e'(pix_i.req_type) == lpf_pkg::REQ_PIXEL);
    in_ready = emit_ready && !pal_busy;
    accept   = pix_i.valid && in_ready;
    load     = accept && is_pixel && layer_en;

    idx_a  = (mode_sel == lpf_pkg::MODE_16) ? {4'h0, pix_i.pixel_data[3:0]}
                                            : pix_i.pixel_data[7:0];
    idx_b  = {4'h0, pix_i.pixel_data[7:4]};
    rng_a  = ({1'b0, idx_a} < ENTRIES_W);
    rng_b  = ({1'b0, idx_b} < ENTRIES_W);
    addr_a = rng_a ? idx_a[AW-1:0] : '0;
    addr_b = rng_b ? idx_b[AW-1:0] : '0;

    wr.sel_we  = accept && !is_pixel && (lpf_pkg::port_e'(pix_i.port) == lpf_pkg::PORT_SEL);
    wr.comp_we = accept && !is_pixel && (lpf_pkg::port_e'(pix_i.port) != lpf_pkg::PORT_SEL);
    wr.port    = lpf_pkg::port_e'(pix_i.port);
    wr.data    = pix_i.pixel_data[7:0];

    meta.mode   = mode_sel;
    meta.zoom   = zoom_sel;
    meta.op_a   = (mode_sel == lpf_pkg::MODE_HI) ? (pix_i.pixel_data != '0) : (idx_a != '0);
    meta.op_b   = (idx_b != '0);
    meta.rng_a  = rng_a;
    meta.rng_b  = rng_b;
    meta.hc_rgb = lpf_pkg::hicolour(pix_i.pixel_data);
  end

  assign pix_i.ready = in_ready;

  lpf_palette #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .AW              (AW)
  ) u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .rd_en_i     (load),
    .rd_addr_a_i (addr_a),
    .rd_addr_b_i (addr_b),
    .busy_o      (pal_busy),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  lpf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .meta_i      (meta),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .ready_o     (emit_ready),
    .pix_o       (pix_o)
  );

endmodule

`default_nettype wire

[hw/rtl/lpf_checker.sv]
// ----------------------------------------------------------------------------
// lpf_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [lpf_pkg::RGB_W-1:0] out_rgb_i,
  input wire logic                      out_opaque_i,
  input wire logic                      out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("pixel beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_rgb_i) && $stable(out_opaque_i) && $stable(out_last_i))
    else $error("stalled pixel beat changed");

  a_mid_word_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && !out_last_i |-> !in_ready_i)
    else $error("request taken while a word is still being expanded");

  a_transparent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_opaque_i |-> (out_rgb_i == '0))
    else $error("transparent beat with nonzero colour");

endmodule

bind layer_pixel_palette_formatter_unit lpf_checker u_lpf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (pix_o.valid),
  .out_ready_i  (pix_o.ready),
  .out_rgb_i    (pix_o.rgb),
  .out_opaque_i (pix_o.opaque),
  .out_last_i   (pix_o.last)
);

`default_nettype wire
